// File: rtl/nssm_pkg.sv
package nssm_pkg;

    localparam int MAX_QUERY   = 32;
    localparam int QUERY_WORDS = 4;
    localparam int WORD_BITS   = 64;
    localparam int QLEN_BITS   = 6;
    localparam int QIDX_BITS   = $clog2(MAX_QUERY);
    localparam int POS_BITS    = 16;
    localparam int OUT_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int BYTE_BITS   = 8;
    localparam int OUT_TDATA_BITS = 3 * OUT_BITS;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_QUERY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUERY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUERY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUERY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUERY_LENGTH = 3'd4;

    localparam logic [QLEN_BITS-1:0] QLEN_RESET = 6'd1;
    localparam logic [POS_BITS-1:0]  POS_MAX    = {POS_BITS{1'b1}};
    localparam logic [OUT_BITS-1:0]  OUT_MAX    = {OUT_BITS{1'b1}};

    typedef logic [BYTE_BITS-1:0] byte_t;
    typedef logic [MAX_QUERY*BYTE_BITS-1:0] query_t;

    typedef struct packed {
        query_t               query;
        logic [QLEN_BITS-1:0] qlen;
    } cfg_t;

    typedef struct packed {
        byte_t text_byte;
        logic  line_end;
    } beat_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] match_number;
        logic [OUT_BITS-1:0] match_col;
        logic [OUT_BITS-1:0] match_row;
    } result_t;

endpackage

// File: rtl/nssm_cfg.sv
module nssm_cfg
    import nssm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_en,
    input  logic [CFG_IDX_BITS-1:0] wr_index,
    input  logic [WORD_BITS-1:0]    wr_data,
    output cfg_t                    cfg
);

    query_t               query_reg;
    logic [QLEN_BITS-1:0] qlen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_reg <= '0;
            qlen_reg  <= QLEN_RESET;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_QUERY_WORD_0: query_reg[0*WORD_BITS +: WORD_BITS] <= wr_data;
                REG_QUERY_WORD_1: query_reg[1*WORD_BITS +: WORD_BITS] <= wr_data;
                REG_QUERY_WORD_2: query_reg[2*WORD_BITS +: WORD_BITS] <= wr_data;
                REG_QUERY_WORD_3: query_reg[3*WORD_BITS +: WORD_BITS] <= wr_data;
                REG_QUERY_LENGTH: qlen_reg <= wr_data[QLEN_BITS-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg.query = query_reg;
    assign cfg.qlen  = qlen_reg;

endmodule

// File: rtl/nssm_match.sv
module nssm_match
    import nssm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    advance,
    input  beat_t   beat,
    output logic    hit,
    output result_t result
);

    byte_t               window_reg [MAX_QUERY];
    byte_t               window_shift [MAX_QUERY];
    logic [POS_BITS-1:0] column_reg;
    logic [POS_BITS-1:0] row_reg;
    logic [POS_BITS-1:0] allowed_reg;
    logic [OUT_BITS-1:0] matches_reg;

    logic [QLEN_BITS-1:0] qlen_eff;
    logic [POS_BITS-1:0]  column_next;
    logic [POS_BITS-1:0]  start;
    logic [MAX_QUERY-1:0] eq;
    logic                 long_enough;

    assign qlen_eff = (cfg.qlen > QLEN_BITS'(MAX_QUERY)) ? QLEN_BITS'(MAX_QUERY) : cfg.qlen;

    // window after this byte, newest first
    always_comb begin
        window_shift[0] = beat.text_byte;
        for (int j = 1; j < MAX_QUERY; j++) begin
            window_shift[j] = window_reg[j-1];
        end
    end

    assign column_next = (column_reg == POS_MAX) ? POS_MAX : column_reg + 1'b1;

    // window slot j holds query byte qlen-1-j
    always_comb begin
        logic [QLEN_BITS-1:0] k;
        for (int j = 0; j < MAX_QUERY; j++) begin
            k = qlen_eff - QLEN_BITS'(j) - 1'b1;
            if (QLEN_BITS'(j) < qlen_eff) begin
                eq[j] = (window_shift[j] ==
                         cfg.query[{k[QIDX_BITS-1:0], 3'b000} +: BYTE_BITS]);
            end else begin
                eq[j] = 1'b1;
            end
        end
    end

    assign long_enough = (qlen_eff != '0) && (column_next >= POS_BITS'(qlen_eff));
    assign start       = column_next - POS_BITS'(qlen_eff);
    assign hit         = !beat.line_end && long_enough && (&eq) && (start >= allowed_reg);

    assign result.match_row    = row_reg;
    assign result.match_col    = start;
    assign result.match_number = matches_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_QUERY; j++) begin
                window_reg[j] <= '0;
            end
            column_reg  <= '0;
            row_reg     <= '0;
            allowed_reg <= '0;
            matches_reg <= '0;
        end else if (advance) begin
            if (beat.line_end) begin
                for (int j = 0; j < MAX_QUERY; j++) begin
                    window_reg[j] <= '0;
                end
                column_reg  <= '0;
                allowed_reg <= '0;
                row_reg     <= (row_reg == POS_MAX) ? POS_MAX : row_reg + 1'b1;
            end else begin
                for (int j = 0; j < MAX_QUERY; j++) begin
                    window_reg[j] <= window_shift[j];
                end
                column_reg <= column_next;
                if (hit) begin
                    allowed_reg <= column_next;
                    matches_reg <= (matches_reg == OUT_MAX) ? OUT_MAX : matches_reg + 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/nonoverlapping_substring_matcher.sv
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+--------------------------------------------
// s_        | in  | s_tvalid/s_tready  | s_tdata = text_byte, s_tlast = line_end
// m_        | out | m_tvalid/m_tready  | m_tdata = match_row, match_col, match_number
// cfg_      | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// one beat per cycle unless a stalled m_ side holds the flow: a beat is held
// in the input register, then the window compare against all query bytes runs
// in parallel and a match lands in the output register before it goes out on m_
// synchronous active-low reset clears the query, counters and window;
// query length resets to 1
// a stalled m_ side holds the result; the input register keeps taking beats
// as long as the output register drains or is empty
module nonoverlapping_substring_matcher
    import nssm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [BYTE_BITS-1:0]      s_tdata,   // [7:0] text_byte
    input  logic                      s_tlast,   // line_end
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // [15:0] row, [31:16] col, [47:32] number
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data
);

    cfg_t    cfg;
    beat_t   beat_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    out_free;
    logic    advance;
    logic    hit;
    result_t result;

    assign cfg_ready = 1'b1;

    nssm_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // output register free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            beat_reg.text_byte <= s_tdata;
            beat_reg.line_end  <= s_tlast;
        end
    end

    nssm_match u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .beat    (beat_reg),
        .hit     (hit),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && hit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
